// File: rtl/cfd_pkg.sv
package cfd_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;
    localparam logic [7:0] TYPE_BYTE    = 8'h51;
    localparam int         SUM_LEN      = 12;
    localparam logic [3:0] SUM_POS      = 4'(SUM_LEN);
    localparam logic [3:0] LAST_POS     = 4'(SUM_LEN + 1);
    localparam logic [3:0] HUNT_POS     = 4'd0;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_TRAILER = 2'd1,
        STATUS_BAD_SUM     = 2'd2,
        STATUS_BAD_TYPE    = 2'd3
    } frame_status_t;

endpackage

// File: rtl/camera_frame_deframer.sv
// an accepted trailer byte passes the input register, and its frame result is then registered in the output register
// throughput: one byte per cycle; the input register only holds while a finished
// frame result still waits in the output register
// reset: asynchronous, active low; clears the hunt position, running sum and valids
// the stored frame bytes are not reset and are always written before being read
module camera_frame_deframer
    import cfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [1:0]         frame_status,
    output logic signed [15:0] x_distance,
    output logic signed [15:0] y_distance,
    output logic signed [15:0] track_offset,
    output logic [7:0]         find_flag,
    output logic signed [15:0] line_detect
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic [3:0]    pos_reg;
    logic [3:0]    pos_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [7:0]    frame_reg [SUM_LEN];

    logic          res_valid_reg;
    frame_status_t status_reg;
    frame_status_t status_next;
    logic [15:0]   x_reg;
    logic [15:0]   y_reg;
    logic [15:0]   track_reg;
    logic [7:0]    find_reg;
    logic [15:0]   line_reg;

    logic          hunting;
    logic          frame_end;
    logic          out_free;
    logic          advance;
    logic          rx_take;

    assign hunting   = (pos_reg == HUNT_POS) || (pos_reg > LAST_POS);
    assign frame_end = (pos_reg == LAST_POS);
    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && (!frame_end || out_free);
    assign rx_stall  = s1_valid_reg && !advance;
    assign rx_take   = rx_valid && !rx_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // frame position and checksum
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (hunting)
        begin
            pos_next = HUNT_POS;
            if (s1_byte_reg == SYNC_BYTE)
            begin
                pos_next = 4'd1;
                sum_next = s1_byte_reg;
            end
        end
        else if (pos_reg < SUM_POS)
        begin
            pos_next = pos_reg + 4'd1;
            sum_next = sum_reg + s1_byte_reg;
        end
        else if (pos_reg == SUM_POS)
        begin
            pos_next = pos_reg + 4'd1;
            sum_next = sum_reg ^ s1_byte_reg;
        end
        else
        begin
            pos_next = HUNT_POS;
            sum_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= HUNT_POS;
            sum_reg <= 8'd0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // frame byte store, one slot per position before the checksum byte
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < SUM_LEN; i++)
            begin
                if (i == 0)
                begin
                    if (hunting && s1_byte_reg == SYNC_BYTE)
                    begin
                        frame_reg[i] <= s1_byte_reg;
                    end
                end
                else if (pos_reg == 4'(i))
                begin
                    frame_reg[i] <= s1_byte_reg;
                end
            end
        end
    end

    // frame checks in priority order
    always_comb
    begin
        if (s1_byte_reg != TRAILER_BYTE)
        begin
            status_next = STATUS_BAD_TRAILER;
        end
        else if (sum_reg != 8'd0)
        begin
            status_next = STATUS_BAD_SUM;
        end
        else if (frame_reg[1] != TYPE_BYTE)
        begin
            status_next = STATUS_BAD_TYPE;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && frame_end)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_end)
        begin
            status_reg <= status_next;
            if (status_next == STATUS_OK)
            begin
                x_reg     <= {frame_reg[3], frame_reg[4]};
                y_reg     <= {frame_reg[5], frame_reg[6]};
                track_reg <= {frame_reg[7], frame_reg[8]};
                find_reg  <= frame_reg[9];
                line_reg  <= {frame_reg[10], frame_reg[11]};
            end
            else
            begin
                x_reg     <= 16'd0;
                y_reg     <= 16'd0;
                track_reg <= 16'd0;
                find_reg  <= 8'd0;
                line_reg  <= 16'd0;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign frame_status = status_reg;
    assign x_distance   = signed'(x_reg);
    assign y_distance   = signed'(y_reg);
    assign track_offset = signed'(track_reg);
    assign find_flag    = find_reg;
    assign line_detect  = signed'(line_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> (s1_valid_reg && frame_end && res_valid_reg && res_stall))
        else $error("input held without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && frame_end) |=> (pos_reg == HUNT_POS && sum_reg == 8'd0 && res_valid_reg))
        else $error("frame end did not return to hunting with a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != STATUS_OK) |->
            (x_reg == 16'd0 && y_reg == 16'd0 && track_reg == 16'd0 &&
             find_reg == 8'd0 && line_reg == 16'd0))
        else $error("bad frame carries non-zero fields");

endmodule
